/* hw/rtl/rgb2hsv_pkg.sv */
`timescale 1ns / 1ps

package rgb2hsv_pkg;

    // channel and result widths
    localparam int CH_W   = 8;
    localparam int QUO_W  = 8;

    // hue numerator n + k*d lies in 0..6*d, d up to 255
    localparam int NUM_W  = 11;
    // hue dividend 255*num and divisor 6*d
    localparam int HNUM_W = 19;
    localparam int HDEN_W = 11;
    // saturation dividend 255*d, divisor mx
    localparam int SNUM_W = 16;

    // one quotient bit per divider stage
    localparam int DIV_STAGES = QUO_W;
    // three prep stages ahead of the divider stages
    localparam int PREP_STAGES = 3;
    localparam int PIPE_DEPTH  = PREP_STAGES + DIV_STAGES;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_RED_EN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN_EN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE_EN  = 2'd2;

    // which channel holds the maximum
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    typedef logic [1:0] max_sel_t;

endpackage

/* hw/rtl/rgb_to_hsv_converter_unit.sv */
`timescale 1ns / 1ps

// each input transfer passes the prep stages, then the divider stages, on its way to the m_ side
// throughput: one pixel per cycle while the output is not stalled; two restoring dividers, one quotient bit per stage
// the whole pipeline advances while the output register is empty or being taken
// reset: synchronous active-low aresetn clears all stage valid bits and sets all
// three channel enables to 1; data registers are not reset
module rgb_to_hsv_converter_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // input pixel stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [3*rgb2hsv_pkg::CH_W-1:0]        s_tdata,   // red, green, blue

    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [3*rgb2hsv_pkg::CH_W-1:0]        m_tdata,   // hue, saturation, brightness

    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [rgb2hsv_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rgb2hsv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int CH_W   = rgb2hsv_pkg::CH_W;
    localparam int QUO_W  = rgb2hsv_pkg::QUO_W;
    localparam int NUM_W  = rgb2hsv_pkg::NUM_W;
    localparam int HNUM_W = rgb2hsv_pkg::HNUM_W;
    localparam int HDEN_W = rgb2hsv_pkg::HDEN_W;
    localparam int SNUM_W = rgb2hsv_pkg::SNUM_W;
    localparam int NDIV   = rgb2hsv_pkg::DIV_STAGES;
    localparam int DEPTH  = rgb2hsv_pkg::PIPE_DEPTH;

    // ------------------------------------------------------------------
    // channel enables
    // ------------------------------------------------------------------
    logic red_en_reg;
    logic green_en_reg;
    logic blue_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_en_reg   <= 1'b1;
            green_en_reg <= 1'b1;
            blue_en_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rgb2hsv_pkg::REG_RED_EN:   red_en_reg   <= cfg_wdata[0];
                rgb2hsv_pkg::REG_GREEN_EN: green_en_reg <= cfg_wdata[0];
                rgb2hsv_pkg::REG_BLUE_EN:  blue_en_reg  <= cfg_wdata[0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: all stages move together when the output frees up
    // ------------------------------------------------------------------
    logic             adv;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    assign adv      = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[DEPTH-1];
    assign vld_next = {vld_reg[DEPTH-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: mask channels, find max and min, pick the max channel
    // ------------------------------------------------------------------
    logic [CH_W-1:0]           r_in, g_in, b_in;
    logic [CH_W-1:0]           mx_in, mn_in;
    rgb2hsv_pkg::max_sel_t     sel_in;

    logic [CH_W-1:0]           p1_r_reg, p1_g_reg, p1_b_reg;
    logic [CH_W-1:0]           p1_mx_reg, p1_mn_reg;
    rgb2hsv_pkg::max_sel_t     p1_sel_reg;

    always_comb begin
        r_in = red_en_reg   ? s_tdata[CH_W-1:0]        : '0;
        g_in = green_en_reg ? s_tdata[2*CH_W-1:CH_W]   : '0;
        b_in = blue_en_reg  ? s_tdata[3*CH_W-1:2*CH_W] : '0;

        // ties go to red first, then green
        if (r_in >= g_in && r_in >= b_in) begin
            sel_in = rgb2hsv_pkg::SEL_RED;
            mx_in  = r_in;
        end else if (g_in >= b_in) begin
            sel_in = rgb2hsv_pkg::SEL_GREEN;
            mx_in  = g_in;
        end else begin
            sel_in = rgb2hsv_pkg::SEL_BLUE;
            mx_in  = b_in;
        end

        mn_in = (r_in <= g_in) ? r_in : g_in;
        if (b_in < mn_in) begin
            mn_in = b_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_r_reg   <= r_in;
            p1_g_reg   <= g_in;
            p1_b_reg   <= b_in;
            p1_mx_reg  <= mx_in;
            p1_mn_reg  <= mn_in;
            p1_sel_reg <= sel_in;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: d = mx - mn and hue numerator n + k*d (always 0..6*d)
    // ------------------------------------------------------------------
    logic [CH_W-1:0]  d_p2;
    logic [NUM_W-1:0] d_w;
    logic [NUM_W-1:0] num_p2;

    logic [CH_W-1:0]  p2_d_reg;
    logic [NUM_W-1:0] p2_num_reg;
    logic [CH_W-1:0]  p2_mx_reg;

    always_comb begin
        d_p2 = p1_mx_reg - p1_mn_reg;
        d_w  = NUM_W'(d_p2);
        case (p1_sel_reg)
            rgb2hsv_pkg::SEL_RED: begin
                if (p1_g_reg >= p1_b_reg) begin
                    num_p2 = NUM_W'(p1_g_reg) - NUM_W'(p1_b_reg);
                end else begin
                    // wrap past 360 degrees: 6d - (b - g)
                    num_p2 = (d_w << 2) + (d_w << 1) + NUM_W'(p1_g_reg)
                           - NUM_W'(p1_b_reg);
                end
            end
            rgb2hsv_pkg::SEL_GREEN: begin
                num_p2 = (d_w << 1) + NUM_W'(p1_b_reg) - NUM_W'(p1_r_reg);
            end
            default: begin
                num_p2 = (d_w << 2) + NUM_W'(p1_r_reg) - NUM_W'(p1_g_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_d_reg   <= d_p2;
            p2_num_reg <= num_p2;
            p2_mx_reg  <= p1_mx_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: scale by 255 (shift and subtract), form divisors
    // feeds divider slot 0
    // ------------------------------------------------------------------
    logic [HNUM_W-1:0] hrem_reg [0:NDIV];
    logic [HDEN_W-1:0] hden_reg [0:NDIV];
    logic [QUO_W-1:0]  hq_reg   [0:NDIV];
    logic [SNUM_W-1:0] srem_reg [0:NDIV];
    logic [CH_W-1:0]   sden_reg [0:NDIV];
    logic [QUO_W-1:0]  sq_reg   [0:NDIV];
    logic              grey_reg [0:NDIV];

    logic [HNUM_W-1:0] hnum_p3;
    logic [HDEN_W-1:0] hden_p3;
    logic [SNUM_W-1:0] snum_p3;

    always_comb begin
        hnum_p3 = (HNUM_W'(p2_num_reg) << CH_W) - HNUM_W'(p2_num_reg);
        hden_p3 = (HDEN_W'(p2_d_reg) << 2) + (HDEN_W'(p2_d_reg) << 1);
        snum_p3 = (SNUM_W'(p2_d_reg) << CH_W) - SNUM_W'(p2_d_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hrem_reg[0] <= hnum_p3;
            hden_reg[0] <= hden_p3;
            hq_reg[0]   <= '0;
            srem_reg[0] <= snum_p3;
            sden_reg[0] <= p2_mx_reg;
            sq_reg[0]   <= '0;
            // d == 0 forces hue and saturation to zero (covers black too)
            grey_reg[0] <= (p2_d_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // divider stages: restoring division, msb of the quotient first
    // both quotients are known to fit in 8 bits when the divisor is nonzero
    // ------------------------------------------------------------------
    logic [HNUM_W-1:0] hrem_next [1:NDIV];
    logic [QUO_W-1:0]  hq_next   [1:NDIV];
    logic [SNUM_W-1:0] srem_next [1:NDIV];
    logic [QUO_W-1:0]  sq_next   [1:NDIV];

    for (genvar j = 1; j <= NDIV; j++) begin : g_div
        localparam int SH = NDIV - j;

        logic [HNUM_W-1:0] hsub;
        logic [SNUM_W-1:0] ssub;
        logic              hge;
        logic              sge;

        always_comb begin
            hsub = HNUM_W'(hden_reg[j-1]) << SH;
            ssub = SNUM_W'(sden_reg[j-1]) << SH;
            hge  = (hrem_reg[j-1] >= hsub);
            sge  = (srem_reg[j-1] >= ssub);
            hrem_next[j] = hge ? (hrem_reg[j-1] - hsub) : hrem_reg[j-1];
            srem_next[j] = sge ? (srem_reg[j-1] - ssub) : srem_reg[j-1];
            hq_next[j]   = hq_reg[j-1] | (QUO_W'(hge) << SH);
            sq_next[j]   = sq_reg[j-1] | (QUO_W'(sge) << SH);
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                hrem_reg[j] <= hrem_next[j];
                hden_reg[j] <= hden_reg[j-1];
                hq_reg[j]   <= hq_next[j];
                srem_reg[j] <= srem_next[j];
                sden_reg[j] <= sden_reg[j-1];
                sq_reg[j]   <= sq_next[j];
                grey_reg[j] <= grey_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // output: last divider slot is the output register
    // brightness is mx, which the saturation divisor carries along
    // ------------------------------------------------------------------
    assign m_tdata = {sden_reg[NDIV],
                      grey_reg[NDIV] ? '0 : sq_reg[NDIV],
                      grey_reg[NDIV] ? '0 : hq_reg[NDIV]};

endmodule

/* hw/rtl/rgb2hsv_checker.sv */
`timescale 1ns / 1ps

module rgb2hsv_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [3*rgb2hsv_pkg::CH_W-1:0]      m_tdata
);

    localparam int CH_W = rgb2hsv_pkg::CH_W;

    // stalled result stays put
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped during stall");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed during stall");

    // input side opens whenever the output register can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output register state");

    // zero saturation means a grey pixel, so hue must be zero too
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2*CH_W-1:CH_W] == '0) |-> (m_tdata[CH_W-1:0] == '0))
        else $error("nonzero hue with zero saturation");

endmodule

bind rgb_to_hsv_converter_unit rgb2hsv_checker u_rgb2hsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/tb_rgb_to_hsv_converter_unit.sv */
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_unit;

    localparam int CH_W       = rgb2hsv_pkg::CH_W;
    localparam int QUO_W      = rgb2hsv_pkg::QUO_W;
    localparam int CFG_ADDR_W = rgb2hsv_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = rgb2hsv_pkg::CFG_DATA_W;
    localparam int PIPE_DEPTH = rgb2hsv_pkg::PIPE_DEPTH;

    // index past the last register, writes to it must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    // pixel and result layouts, first field in the highest bits
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [QUO_W-1:0] brightness;
        logic [QUO_W-1:0] saturation;
        logic [QUO_W-1:0] hue;
    } hsv_t;

    // expected hsv values in transfer order, plus a private copy of the enables
    class hsv_scoreboard;
        hsv_t        expected_q[$];
        bit          red_on   = 1'b1;
        bit          green_on = 1'b1;
        bit          blue_on  = 1'b1;
        int unsigned mismatches = 0;

        function void set_enable(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                rgb2hsv_pkg::REG_RED_EN:   red_on   = val[0];
                rgb2hsv_pkg::REG_GREEN_EN: green_on = val[0];
                rgb2hsv_pkg::REG_BLUE_EN:  blue_on  = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function hsv_t predict_hsv(pixel_t px);
            int unsigned r, g, b, mx, mn, d, num;
            hsv_t        res;
            r = red_on   ? px.red   : 0;
            g = green_on ? px.green : 0;
            b = blue_on  ? px.blue  : 0;
            mx = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            mn = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            res = '0;
            if (d != 0) begin
                // red wins a tie for largest, then green
                if (mx == r) begin
                    num = (g >= b) ? g - b : 6 * d - (b - g);
                end else if (mx == g) begin
                    num = 2 * d + b - r;
                end else begin
                    num = 4 * d + r - g;
                end
                res.hue = QUO_W'((255 * num) / (6 * d));
            end
            if (mx != 0)
                res.saturation = QUO_W'((255 * d) / mx);
            res.brightness = QUO_W'(mx);
            return res;
        endfunction

        function void note_pixel(pixel_t px);
            expected_q.push_back(predict_hsv(px));
        endfunction

        task report_mismatch(string msg);
            $display("tb: mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(hsv_t got);
            hsv_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = expected_q.pop_front();
                if (got.hue !== want.hue)
                    report_mismatch($sformatf("hue %0d, want %0d", got.hue, want.hue));
                if (got.saturation !== want.saturation)
                    report_mismatch($sformatf("saturation %0d, want %0d",
                                              got.saturation, want.saturation));
                if (got.brightness !== want.brightness)
                    report_mismatch($sformatf("brightness %0d, want %0d",
                                              got.brightness, want.brightness));
            end
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [3*CH_W-1:0]      s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [3*CH_W-1:0]      m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    hsv_scoreboard pix_sb = new;

    // idle chance in percent, per pixel on the sender side and per cycle on the receiver side, zero means no idling
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    // request for a long receiver hold-off, picked up by the sink process
    int unsigned rx_hold_len = 0;

    rgb_to_hsv_converter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // watchdog, far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: check every transfer against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            pix_sb.check_result(hsv_t'(m_tdata));
    end

    // result sink: random stall bursts, or one long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_len != 0) begin
                stall_left  = rx_hold_len;
                rx_hold_len = 0;
            end else if (stall_left == 0 && rx_idle_pct != 0
                         && $urandom_range(1, 100) <= rx_idle_pct) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left != 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // register write, only issued while the pipeline is empty
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(posedge aclk);
        pix_sb.set_enable(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // hold valid until the block takes the pixel
    task automatic send_pixel(input pixel_t px);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(posedge aclk); while (!s_tready);
        pix_sb.note_pixel(px);
    endtask

    task automatic send_rgb(input int r, input int g, input int b);
        pixel_t px;
        px.red   = CH_W'(r);
        px.green = CH_W'(g);
        px.blue  = CH_W'(b);
        send_pixel(px);
    endtask

    // sender gap with valid low, data lines carry junk meanwhile
    task automatic sender_gap();
        int unsigned len;
        len = $urandom_range(1, 18);
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tdata  = 24'($urandom);
        repeat (len - 1) @(negedge aclk);
    endtask

    // random pixels weighted toward greys, ties and channel extremes
    function automatic pixel_t rand_pixel();
        pixel_t          px;
        logic [CH_W-1:0] v;
        logic [CH_W-1:0] corner[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
        px = pixel_t'($urandom);
        v  = CH_W'($urandom);
        case ($urandom_range(0, 11))
            0: begin
                px.red   = v;
                px.green = v;
                px.blue  = v;
            end
            1: px.green = px.red;
            2: px.blue  = px.green;
            3: px.blue  = px.red;
            4: begin
                px.red   = corner[$urandom_range(0, 3)];
                px.green = corner[$urandom_range(0, 3)];
                px.blue  = corner[$urandom_range(0, 3)];
            end
            5: begin
                // near-grey, small hue spread
                px.green = px.red + CH_W'($urandom_range(0, 2));
                px.blue  = px.red - CH_W'($urandom_range(0, 2));
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic send_random(input int unsigned count);
        repeat (count) begin
            if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
                sender_gap();
            send_pixel(rand_pixel());
        end
    endtask

    // sender stops offering and waits until every expected result has come
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pix_sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_enables(input logic [2:0] rgb_en);
        wait_drain();
        write_reg(rgb2hsv_pkg::REG_RED_EN,   rgb_en[2]);
        write_reg(rgb2hsv_pkg::REG_GREEN_EN, rgb_en[1]);
        write_reg(rgb2hsv_pkg::REG_BLUE_EN,  rgb_en[0]);
    endtask

    initial begin : stimulus
        // enable settings walked by the random phases, red in the top bit
        logic [2:0] en_list[8] = '{3'b000, 3'b100, 3'b011, 3'b110,
                                   3'b010, 3'b101, 3'b001, 3'b111};
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part at reset enables, no idling
        set_enables(3'b111);
        // write to a missing register must leave the enables alone
        write_reg(REG_UNUSED, 1'b0);
        send_rgb(0, 0, 0);          // black pixel, saturation zero
        send_rgb(255, 255, 255);    // white, grey hue
        send_rgb(128, 128, 128);    // mid grey
        send_rgb(255, 0, 0);        // pure red
        send_rgb(255, 0, 10);       // red largest, blue above green wraps hue
        send_rgb(255, 10, 0);
        send_rgb(0, 255, 0);        // pure green
        send_rgb(0, 0, 255);        // pure blue
        send_rgb(200, 200, 50);     // red and green tie, red wins
        send_rgb(10, 200, 200);     // green and blue tie, green wins
        send_rgb(200, 50, 200);     // red and blue tie, red wins
        send_rgb(1, 0, 0);          // smallest nonzero
        send_rgb(255, 254, 0);
        send_rgb(0, 1, 255);
        send_rgb(254, 255, 255);
        send_rgb(255, 0, 255);
        send_rgb(1, 1, 0);
        send_rgb(0, 255, 255);

        // back pressure: long hold-off while the sender keeps pushing
        wait_drain();
        rx_hold_len = 150;
        send_random(60);
        wait_drain();

        // random phases over the enable settings, idling switched per phase
        for (int i = 0; i < 8; i++) begin
            set_enables(en_list[i]);
            tx_idle_pct = (i % 3 == 0) ? 0 : 10 * (i % 4 + 1);
            rx_idle_pct = (i % 3 == 1) ? 0 : 8 * (i % 5 + 1);
            send_random(190);
        end

        // closing stretch at full rate, no idling anywhere
        set_enables(3'b111);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(150);

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait_drain();
        repeat (PIPE_DEPTH + 8) @(posedge aclk);

        if (pix_sb.mismatches == 0 && pix_sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* rgb_to_hsv_converter_unit.f */
hw/rtl/rgb2hsv_pkg.sv
hw/rtl/rgb_to_hsv_converter_unit.sv
hw/rtl/rgb2hsv_checker.sv
verif/tb_rgb_to_hsv_converter_unit.sv
